FILE: sv/ocre_pkg.sv
// Shared constants for the column refresh engine: register indexes, reset values and parameter defaults.
package ocre_pkg;

  localparam int MAX_PAGES_DEF     = 16;
  localparam int STORE_BYTES_DEF   = 2048;
  localparam int COL_LOW_BASE_DEF  = 0;
  localparam int COL_HIGH_BASE_DEF = 16;
  localparam int PAGE_CMD_BASE_DEF = 176;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_REVERSE = 3'd4;

  localparam logic [7:0] PANEL_WIDTH_RST  = 8'd64;
  localparam logic [7:0] PANEL_HEIGHT_RST = 8'd128;
  localparam logic [7:0] REGION_START_RST = 8'd0;
  localparam logic [7:0] REGION_END_RST   = 8'd255;

endpackage

FILE: sv/oled_column_refresh_engine.sv
// Frame store and column refresh sequencer for a vertically addressed 1 bpp OLED panel.
//
// Write items store one byte in the frame store and the block is ready again right after.
// A kick item takes two setup steps (COUNT, CALC), then three command outputs (column
// low, column high, page), then for each page eight frame store reads (one row per cycle
// through the single read port, data registered) plus a drain and an emit step; the
// result side can stall the command and emit steps. A kick whose index lies at or past
// the sweep count gives one flagged result instead, after the setup steps. The input stall
// stays high for the whole kick. Configuration writes are always taken.
module oled_column_refresh_engine #(
  parameter int MAX_PAGES     = ocre_pkg::MAX_PAGES_DEF,
  parameter int STORE_BYTES   = ocre_pkg::STORE_BYTES_DEF,
  parameter int COL_LOW_BASE  = ocre_pkg::COL_LOW_BASE_DEF,
  parameter int COL_HIGH_BASE = ocre_pkg::COL_HIGH_BASE_DEF,
  parameter int PAGE_CMD_BASE = ocre_pkg::PAGE_CMD_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [10:0]                    in_store_address,
  input  logic [7:0]                     in_store_data,
  input  logic [6:0]                     in_sweep_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_is_command,
  output logic                           out_last,
  output logic [7:0]                     out_sweep_count,
  output logic                           out_index_error,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ocre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int RA_W = 13;  // row address: up to 128 rows of 32 bytes plus column byte

  localparam logic [11:0]     STORE_LIMIT = 12'(STORE_BYTES);
  localparam logic [RA_W-1:0] STORE_LIMIT_RA = RA_W'(STORE_BYTES);
  localparam logic [PW-1:0]   PAGE_CAP = PW'(MAX_PAGES);
  localparam logic [7:0]      LOW_BASE = 8'(COL_LOW_BASE);
  localparam logic [7:0]      HIGH_BASE = 8'(COL_HIGH_BASE);
  localparam logic [7:0]      PAGE_BASE = 8'(PAGE_CMD_BASE);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_COUNT = 4'd1;
  localparam logic [3:0] ST_CALC  = 4'd2;
  localparam logic [3:0] ST_ERR   = 4'd3;
  localparam logic [3:0] ST_CLO   = 4'd4;
  localparam logic [3:0] ST_CHI   = 4'd5;
  localparam logic [3:0] ST_CPG   = 4'd6;
  localparam logic [3:0] ST_PAGE  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  // configuration registers
  logic [7:0] width_r, height_r, start_r, end_r;
  logic       reverse_r;

  // sequencer state
  logic [3:0]      state_r, state_nxt;
  logic [6:0]      idx_r;
  logic [7:0]      count_r;
  logic [7:0]      column_r;
  logic [5:0]      row_bytes_r;
  logic [PW-1:0]   pages_r, page_r;
  logic [RA_W-1:0] addr_r;
  logic [7:0]      y_r;
  logic [3:0]      bit_r;
  logic [7:0]      byte_r;
  logic            rd_ok_r;

  // frame store
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q;
  logic       wr_en, rd_en;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r, out_count_r;
  logic       out_cmd_r, out_last_r, out_err_r;
  logic       out_load;
  logic [7:0] load_byte;
  logic       load_cmd, load_last, load_err;
  logic       slot_free;

  // setup arithmetic
  logic [7:0]  clamp_end;
  logic [7:0]  count_calc;
  logic [7:0]  column_calc;
  logic [8:0]  rb_sum, pg_sum;
  logic [5:0]  ht_pages;
  logic [PW-1:0] page_inc;

  logic in_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign wr_en = in_xfer && !in_op && ({1'b0, in_store_address} < STORE_LIMIT);
  assign rd_en = (state_r == ST_PAGE) && (bit_r < 4'd8);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_store_address[AW-1:0]] <= in_store_data;
    end
    if (rd_en) begin
      mem_q <= mem[addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= ocre_pkg::PANEL_WIDTH_RST;
      height_r  <= ocre_pkg::PANEL_HEIGHT_RST;
      start_r   <= ocre_pkg::REGION_START_RST;
      end_r     <= ocre_pkg::REGION_END_RST;
      reverse_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ocre_pkg::REG_PANEL_WIDTH:   width_r   <= cfg_data;
        ocre_pkg::REG_PANEL_HEIGHT:  height_r  <= cfg_data;
        ocre_pkg::REG_REGION_START:  start_r   <= cfg_data;
        ocre_pkg::REG_REGION_END:    end_r     <= cfg_data;
        ocre_pkg::REG_SWEEP_REVERSE: reverse_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clamp_end = (end_r < width_r) ? end_r : (width_r - 8'd1);
    if (start_r >= width_r || clamp_end < start_r) begin
      count_calc = 8'd0;
    end else begin
      count_calc = clamp_end - start_r + 8'd1;
    end
    column_calc = reverse_r ? (start_r + count_r - 8'd1 - {1'b0, idx_r})
                            : (start_r + {1'b0, idx_r});
    rb_sum   = {1'b0, width_r} + 9'd7;
    pg_sum   = {1'b0, height_r} + 9'd7;
    ht_pages = pg_sum[8:3];
    page_inc = page_r + PW'(1);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    load_byte = 8'd0;
    load_cmd  = 1'b0;
    load_last = 1'b0;
    load_err  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_op) state_nxt = ST_COUNT;
      end
      ST_COUNT: state_nxt = ST_CALC;
      ST_CALC: begin
        state_nxt = ({1'b0, idx_r} >= count_r) ? ST_ERR : ST_CLO;
      end
      ST_ERR: begin
        load_last = 1'b1;
        load_err  = 1'b1;
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLO: begin
        load_byte = LOW_BASE + {4'd0, column_r[3:0]};
        load_cmd  = 1'b1;
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_CHI;
        end
      end
      ST_CHI: begin
        load_byte = HIGH_BASE + {4'd0, column_r[7:4]};
        load_cmd  = 1'b1;
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_CPG;
        end
      end
      ST_CPG: begin
        load_byte = PAGE_BASE;
        load_cmd  = 1'b1;
        load_last = (pages_r == '0);
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = (pages_r == '0) ? ST_IDLE : ST_PAGE;
        end
      end
      ST_PAGE: begin
        if (bit_r == 4'd8) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        load_byte = byte_r;
        load_last = (page_inc == pages_r);
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = (page_inc == pages_r) ? ST_IDLE : ST_PAGE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_r   <= 4'd0;
      page_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer && in_op) idx_r <= in_sweep_index;
        end
        ST_COUNT: count_r <= count_calc;
        ST_CALC: begin
          column_r    <= column_calc;
          row_bytes_r <= rb_sum[8:3];
          pages_r     <= (ht_pages > 6'(PAGE_CAP)) ? PAGE_CAP : PW'(ht_pages);
          addr_r      <= {{(RA_W - 5){1'b0}}, column_calc[7:3]};
          y_r         <= 8'd0;
          page_r      <= '0;
          bit_r       <= 4'd0;
        end
        ST_PAGE: begin
          // issue one row read per cycle, collect its bit from the registered read data in the next cycle
          if (bit_r < 4'd8) begin
            rd_ok_r <= (y_r < height_r) && (addr_r < STORE_LIMIT_RA);
            addr_r  <= addr_r + {{(RA_W - 6){1'b0}}, row_bytes_r};
            y_r     <= y_r + 8'd1;
          end
          if (bit_r != 4'd0) begin
            byte_r <= {rd_ok_r & mem_q[column_r[2:0]], byte_r[7:1]};
          end
          bit_r <= bit_r + 4'd1;
        end
        ST_EMIT: begin
          if (slot_free) begin
            page_r <= page_inc;
            bit_r  <= 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r  <= load_byte;
      out_cmd_r   <= load_cmd;
      out_last_r  <= load_last;
      out_err_r   <= load_err;
      out_count_r <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_command  = out_cmd_r;
  assign out_last        = out_last_r;
  assign out_sweep_count = out_count_r;
  assign out_index_error = out_err_r;

  a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_last && !out_is_command && out_byte == 8'd0)
    else $error("index error result is not a lone data-free last transfer");

  a_kick_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_op |=> in_stall)
    else $error("kick accepted but sequencer did not go busy");

  a_page_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAGE || state_r == ST_EMIT) |-> page_r < pages_r)
    else $error("page counter ran past page count");

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("output register overwritten while a result waits");

endmodule
